// File: hdl/hrp_pkg.sv
package hrp_pkg;

    localparam int unsigned C_BODY_MAX_DEF = 65535;
    localparam int unsigned C_FIFO_DEPTH   = 2;

    localparam logic [7:0] C_CH_CR    = 8'd13;
    localparam logic [7:0] C_CH_LF    = 8'd10;
    localparam logic [7:0] C_CH_SP    = 8'd32;
    localparam logic [7:0] C_CH_ZERO  = 8'd48;
    localparam logic [7:0] C_CH_NUL   = 8'd0;

    // header keys split into the stored part and the final character
    localparam logic [39:0]  C_STAT_HEAD = "HTTP/";
    localparam logic [7:0]   C_STAT_LAST = "1";
    localparam logic [119:0] C_LEN_HEAD  = "Content-Length:";
    localparam logic [7:0]   C_LEN_LAST  = " ";

    localparam int unsigned C_WIN_BITS = 120;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_WAIT_SP,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_word;

    typedef struct packed {
        logic        in_body;
        logic        body_valid;
        logic [7:0]  body_byte;
        logic [15:0] body_index;
        logic [15:0] status_code;
        logic [31:0] content_length;
        logic        length_seen;
        logic        body_done;
        logic        body_overflow;
    } t_out_word;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       is_nul;
        logic       is_cr;
        logic       is_crlf;
        logic       hit_status;
        logic       hit_length;
    } t_cls;

endpackage

// File: hdl/hrp_if.sv
interface hrp_in_if import hrp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hrp_out_if import hrp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/hrp_front.sv
module hrp_front import hrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrp_in_if.sink     i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_cls       o_cls
);

    logic [C_WIN_BITS-1:0] r_win;
    logic [C_WIN_BITS-1:0] n_win;
    logic [C_WIN_BITS-1:0] win_base;
    logic [7:0]            r_prev;
    logic [7:0]            prev_base;
    logic [7:0]            c;

    assign c         = i_in.data.data_byte;
    assign win_base  = i_in.data.first_byte ? '0 : r_win;
    assign prev_base = i_in.data.first_byte ? 8'd0 : r_prev;
    assign n_win     = {win_base[C_WIN_BITS-9:0], c};

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cls.data_byte  = c;
        o_cls.first_byte = i_in.data.first_byte;
        o_cls.is_nul     = (c == C_CH_NUL);
        o_cls.is_cr      = (c == C_CH_CR);
        o_cls.is_crlf    = (c == C_CH_LF) && (prev_base == C_CH_CR);
        o_cls.hit_status = (c == C_STAT_LAST) && (win_base[39:0] == C_STAT_HEAD);
        o_cls.hit_length = (c == C_LEN_LAST) && (win_base == C_LEN_HEAD);
    end

    // window keeps shifting in the body too; it is only read after a clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_prev <= '0;
        end else if (o_push) begin
            r_win  <= n_win;
            r_prev <= c;
        end
    end

endmodule

// File: hdl/hrp_fifo.sv
module hrp_fifo import hrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_cls o_cls
);

    localparam int unsigned PW = $clog2(C_FIFO_DEPTH);

    t_cls            r_mem [C_FIFO_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(C_FIFO_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_cls   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(C_FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(C_FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/hrp_back.sv
module hrp_back import hrp_pkg::*; #(
    parameter int unsigned BODY_MAX = C_BODY_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_avail,
    input  t_cls       i_cls,
    output logic       o_pop,
    hrp_out_if.source  o_out
);

    localparam logic [15:0] LIMIT_MAX = 16'(BODY_MAX);

    logic        r_blank,  n_blank;
    logic        r_phase,  n_phase;
    t_scan       r_smode,  n_smode;
    logic        r_lscan,  n_lscan;
    logic [15:0] r_status, n_status;
    logic [31:0] r_length, n_length;
    logic        r_found,  n_found;
    logic [15:0] r_limit,  n_limit;
    logic [15:0] r_count,  n_count;

    logic        r_out_valid;
    t_out_word   r_out;
    t_out_word   n_out;

    assign o_pop       = i_avail && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        logic        clr;
        logic [7:0]  c;
        logic [15:0] stat_mul;
        logic [31:0] len_mul;

        clr = i_cls.first_byte;
        c   = i_cls.data_byte;

        n_blank  = clr ? 1'b0 : r_blank;
        n_phase  = clr ? 1'b0 : r_phase;
        n_smode  = clr ? SCAN_IDLE : r_smode;
        n_lscan  = clr ? 1'b0 : r_lscan;
        n_status = clr ? 16'd0 : r_status;
        n_length = clr ? 32'd0 : r_length;
        n_found  = clr ? 1'b0 : r_found;
        n_limit  = clr ? 16'd0 : r_limit;
        n_count  = clr ? 16'd0 : r_count;

        // times ten as two shifts and an add
        stat_mul = {n_status[12:0], 3'b000} + {n_status[14:0], 1'b0};
        len_mul  = {n_length[28:0], 3'b000} + {n_length[30:0], 1'b0};

        n_out                = '0;
        n_out.in_body        = 1'b0;

        if (!n_phase) begin
            if (i_cls.is_nul) begin
                // null bytes only move the window
            end else if (i_cls.is_cr) begin
                n_smode = SCAN_IDLE;
                n_lscan = 1'b0;
            end else if (i_cls.is_crlf) begin
                if (n_blank) begin
                    if (n_found && (n_length < 32'(LIMIT_MAX))) begin
                        n_limit = n_length[15:0];
                    end else begin
                        n_limit = LIMIT_MAX;
                    end
                    n_phase = 1'b1;
                    n_blank = 1'b0;
                end else begin
                    n_blank = 1'b1;
                end
            end else begin
                case (n_smode)
                    SCAN_WAIT_SP: begin
                        if (c == C_CH_SP) n_smode = SCAN_DIGITS;
                    end
                    SCAN_DIGITS: begin
                        if (c == C_CH_SP) begin
                            n_smode = SCAN_DONE;
                        end else begin
                            n_status = stat_mul + {8'd0, c} - {8'd0, C_CH_ZERO};
                        end
                    end
                    default: begin
                    end
                endcase
                if (n_lscan) begin
                    n_length = len_mul + {24'd0, c} - {24'd0, C_CH_ZERO};
                end
                if (i_cls.hit_status) n_smode = SCAN_WAIT_SP;
                if (i_cls.hit_length) begin
                    n_found = 1'b1;
                    n_lscan = 1'b1;
                end
                n_blank = 1'b0;
            end
        end else if (n_count < n_limit) begin
            n_out.body_valid = 1'b1;
            n_out.body_byte  = c;
            n_out.body_index = n_count;
            n_count          = n_count + 16'd1;
        end else begin
            n_out.body_overflow = 1'b1;
        end

        n_out.in_body        = n_phase;
        n_out.status_code    = n_status;
        n_out.content_length = n_length;
        n_out.length_seen    = n_found;
        n_out.body_done      = n_phase && (n_count >= n_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank     <= 1'b0;
            r_phase     <= 1'b0;
            r_smode     <= SCAN_IDLE;
            r_lscan     <= 1'b0;
            r_status    <= '0;
            r_length    <= '0;
            r_found     <= 1'b0;
            r_limit     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_blank  <= n_blank;
                r_phase  <= n_phase;
                r_smode  <= n_smode;
                r_lscan  <= n_lscan;
                r_status <= n_status;
                r_length <= n_length;
                r_found  <= n_found;
                r_limit  <= n_limit;
                r_count  <= n_count;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/http_response_header_parser.sv
// an accepted word goes into the queue, then the back end registers its result
// throughput: one byte per cycle unless a side stalls; each byte's scan and body
// update in the back end is one step on registered state (the times-ten add)
// the front end shifts a 15-byte match window; a two-word queue lets each side stall
// reset (synchronous, active low) clears the window, queue, parse state and output
module http_response_header_parser import hrp_pkg::*; #(
    parameter int unsigned BODY_MAX = C_BODY_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrp_in_if.sink     i_in,
    hrp_out_if.source  o_out
);

    // front to queue
    logic push;
    logic full;
    t_cls front_cls;

    // queue to back
    logic pop;
    logic avail;
    t_cls back_cls;

    // front: shifts the match window and tags each byte with its header role
    hrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cls   (front_cls)
    );

    // short queue decouples byte intake from the parse / body path
    hrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_cls   (back_cls)
    );

    // back: status and length scans, header end, body counting; owns output register
    hrp_back #(
        .BODY_MAX (BODY_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_cls   (back_cls),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: sim/http_response_header_parser_tb.sv
`timescale 1ns / 1ps

module http_response_header_parser_tb;
    import hrp_pkg::*;

    localparam int unsigned BODY_LIMIT  = 65535;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned WIN_DEPTH   = 15;

    // header keys as they sit at the tail of the last sixteen bytes
    localparam logic [47:0]  STATUS_KEY = "HTTP/1";
    localparam logic [127:0] LENGTH_KEY = "Content-Length: ";

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hrp_in_if  in_if ();
    hrp_out_if out_if ();

    http_response_header_parser #(
        .BODY_MAX (BODY_LIMIT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // response bytes waiting for the driver, parse results waiting for the dut
    t_in_word  response_bytes [$];
    t_out_word parsed_words_due [$];

    int unsigned words_pushed   = 0;
    int unsigned words_accepted = 0;
    int unsigned fail_cnt       = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned src_idle_pct   = 6;
    int unsigned snk_idle_pct   = 62;
    bit          in_taken       = 1'b0;

    // parser state mirrored in the testbench
    logic [7:0]  hdr_window [WIN_DEPTH];
    logic [7:0]  last_byte;
    logic        blank_pend;
    logic        in_body_st;
    t_scan       scan_st;
    logic        len_active;
    logic [15:0] status_acc;
    logic [31:0] length_acc;
    logic        length_hit;
    logic [31:0] limit_st;
    logic [15:0] count_st;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_parse();
        for (int k = 0; k < WIN_DEPTH; k++) hdr_window[k] = '0;
        last_byte  = '0;
        blank_pend = 1'b0;
        in_body_st = 1'b0;
        scan_st    = SCAN_IDLE;
        len_active = 1'b0;
        status_acc = '0;
        length_acc = '0;
        length_hit = 1'b0;
        limit_st   = '0;
        count_st   = '0;
    endfunction

    // one word in, one parse result out; updates the mirrored state
    function automatic t_out_word parse_response_byte(t_in_word w);
        logic [7:0]   c;
        logic [7:0]   prev;
        logic [127:0] tail;
        logic         hit_stat;
        logic         hit_len;
        t_out_word    r;
        c    = w.data_byte;
        r    = '0;
        tail = '0;
        if (w.first_byte) clear_parse();
        if (!in_body_st) begin
            // window compare uses the stored bytes plus the current one
            for (int k = 0; k < WIN_DEPTH; k++) tail = {tail[119:0], hdr_window[k]};
            tail     = {tail[119:0], c};
            hit_stat = (tail[47:0] == STATUS_KEY);
            hit_len  = (tail == LENGTH_KEY);
            prev     = last_byte;
            for (int k = 0; k < WIN_DEPTH - 1; k++) hdr_window[k] = hdr_window[k + 1];
            hdr_window[WIN_DEPTH - 1] = c;
            last_byte = c;
            if (c == C_CH_NUL) begin
                // nul only moves the window
            end else if (c == C_CH_CR) begin
                scan_st    = SCAN_IDLE;
                len_active = 1'b0;
            end else if (c == C_CH_LF && prev == C_CH_CR) begin
                if (blank_pend) begin
                    // second crlf in a row: body limit fixed here
                    limit_st   = (length_hit && length_acc < BODY_LIMIT) ? length_acc
                                                                         : 32'(BODY_LIMIT);
                    in_body_st = 1'b1;
                    blank_pend = 1'b0;
                end else begin
                    blank_pend = 1'b1;
                end
            end else begin
                case (scan_st)
                    SCAN_WAIT_SP: begin
                        if (c == C_CH_SP) scan_st = SCAN_DIGITS;
                    end
                    SCAN_DIGITS: begin
                        if (c == C_CH_SP) scan_st = SCAN_DONE;
                        else status_acc = status_acc * 16'd10 + 16'(c) - 16'(C_CH_ZERO);
                    end
                    default: ;
                endcase
                if (len_active) length_acc = length_acc * 32'd10 + 32'(c) - 32'(C_CH_ZERO);
                if (hit_stat) scan_st = SCAN_WAIT_SP;
                if (hit_len) begin
                    length_hit = 1'b1;
                    len_active = 1'b1;
                end
                blank_pend = 1'b0;
            end
        end else if (32'(count_st) < limit_st) begin
            r.body_valid = 1'b1;
            r.body_byte  = c;
            r.body_index = count_st;
            count_st     = count_st + 16'd1;
        end else begin
            // past the limit: dropped
            r.body_overflow = 1'b1;
        end
        r.in_body        = in_body_st;
        r.status_code    = status_acc;
        r.content_length = length_acc;
        r.length_seen    = length_hit;
        r.body_done      = in_body_st && (32'(count_st) >= limit_st);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_word(logic [7:0] b, logic first);
        t_in_word w;
        w.data_byte  = b;
        w.first_byte = first;
        response_bytes.push_back(w);
        words_pushed++;
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++) push_word(s[k], 1'b0);
    endtask

    task automatic push_crlf();
        push_word(C_CH_CR, 1'b0);
        push_word(C_CH_LF, 1'b0);
    endtask

    // decimal digits, with the odd non-digit when noisy
    task automatic push_digits(int unsigned n, bit noisy);
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(7) == 0) push_word(8'($urandom_range(255)), 1'b0);
            else push_word(C_CH_ZERO + 8'($urandom_range(9)), 1'b0);
        end
    endtask

    // printable text, sometimes broken by a nul or a bare lf
    task automatic push_filler(int unsigned n, int unsigned lo_char);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(39))
                0:       push_word(C_CH_NUL, 1'b0);
                1:       push_word(C_CH_LF, 1'b0);
                default: push_word(8'($urandom_range(126, lo_char)), 1'b0);
            endcase
        end
    endtask

    task automatic push_length_header(bit noisy, int unsigned clen);
        push_text("Content-Length: ");
        if (noisy) push_digits($urandom_range(12, 1), 1'b1);
        else push_text($sformatf("%0d", clen));
        push_crlf();
    endtask

    // a mostly well-formed response with random content
    task automatic push_response();
        int unsigned clen;
        int unsigned nhdr;
        int unsigned len_pos;
        int unsigned nbody;
        bit          has_len;
        bit          twice;
        bit          noisy_len;
        clen      = $urandom_range(20);
        has_len   = ($urandom_range(3) != 0);
        twice     = ($urandom_range(9) == 0);
        noisy_len = ($urandom_range(9) == 0);
        nhdr      = $urandom_range(3);
        len_pos   = $urandom_range(nhdr);

        // status line; now and then the previous state is kept
        push_word("H", $urandom_range(9) != 0);
        push_text("TTP/1.");
        push_word(C_CH_ZERO + 8'($urandom_range(1)), 1'b0);
        push_word(C_CH_SP, 1'b0);
        case ($urandom_range(3))
            0:       push_text("200");
            1:       push_digits(3, 1'b0);
            2:       push_digits($urandom_range(7, 1), 1'b0);
            default: push_digits($urandom_range(5, 1), 1'b1);
        endcase
        if ($urandom_range(4) != 0) begin
            push_word(C_CH_SP, 1'b0);
            push_filler($urandom_range(8), 32);
        end
        push_crlf();

        for (int h = 0; h <= nhdr; h++) begin
            if (has_len && h == len_pos) begin
                push_length_header(noisy_len, clen);
                if (twice) push_length_header(noisy_len, clen);
            end
            if (h < nhdr) begin
                push_filler($urandom_range(8, 1), 33);
                push_text(": ");
                push_filler($urandom_range(10), 32);
                push_crlf();
            end
        end
        push_crlf();

        if (has_len && !noisy_len && !twice)
            nbody = $urandom_range(1) ? clen + $urandom_range(2) : $urandom_range(clen);
        else
            nbody = $urandom_range(20);
        for (int k = 0; k < nbody; k++) push_word(8'($urandom_range(255)), 1'b0);
    endtask

    // raw noise, heavy on the characters the parser reacts to
    task automatic push_noise(int unsigned n);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(7))
                0:       b = C_CH_CR;
                1:       b = C_CH_LF;
                2:       b = C_CH_NUL;
                3:       b = C_CH_SP;
                4:       b = C_CH_ZERO + 8'($urandom_range(9));
                default: b = 8'($urandom_range(255));
            endcase
            push_word(b, (k == 0) ? 1'($urandom_range(1)) : 1'b0);
        end
    endtask

    task automatic push_random(int unsigned upto);
        while (words_pushed < upto) begin
            if ($urandom_range(99) < 85) push_response();
            else push_noise($urandom_range(20, 3));
        end
    endtask

    // every queued word accepted and every result checked
    task automatic wait_drained();
        while (words_accepted != words_pushed || parsed_words_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // driver: one word held until taken, gaps at random
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (response_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_if.data  <= response_bytes.pop_front();
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver stalls at random
    always @(negedge i_clk) begin
        out_if.ready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predict on input handshakes, check on output handshakes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        in_taken = i_rst_n && in_if.valid && in_if.ready;
        if (in_taken) begin
            parsed_words_due.push_back(parse_response_byte(in_if.data));
            words_accepted++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (parsed_words_due.size() == 0) begin
                $error("result word with nothing expected");
                fail_cnt++;
            end else begin
                want = parsed_words_due.pop_front();
                check_field("in_body", want.in_body, got.in_body);
                check_field("body_valid", want.body_valid, got.body_valid);
                check_field("body_byte", want.body_byte, got.body_byte);
                check_field("body_index", want.body_index, got.body_index);
                check_field("status_code", want.status_code, got.status_code);
                check_field("content_length", want.content_length, got.content_length);
                check_field("length_seen", want.length_seen, got.length_seen);
                check_field("body_done", want.body_done, got.body_done);
                check_field("body_overflow", want.body_overflow, got.body_overflow);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL http_response_header_parser");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        clear_parse();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: byte extremes, nul, bare lf, blank line with no length
        push_word(8'hff, 1'b1);
        push_word(C_CH_NUL, 1'b0);
        push_word(C_CH_LF, 1'b0);
        push_crlf();
        push_crlf();
        push_word(8'hff, 1'b0);
        push_word(C_CH_NUL, 1'b0);
        // status after a fresh start, then body bytes with the default limit
        push_word("H", 1'b1);
        push_text("TTP/1 9");
        push_crlf();
        push_crlf();
        push_word(C_CH_CR, 1'b0);
        push_word(8'h80, 1'b0);

        // sender nearly always ready, receiver stalls a lot
        push_random(250);
        wait_drained();

        // the other way round
        src_idle_pct = 62;
        snk_idle_pct = 6;
        push_random(500);
        wait_drained();

        // no idling at all
        src_idle_pct = 0;
        snk_idle_pct = 0;
        push_random(700);

        // length above the body maximum: limit clamps to the maximum
        push_word("H", 1'b1);
        push_text("TTP/1.1 200 OK");
        push_crlf();
        push_text("Content-Length: 70000");
        push_crlf();
        push_crlf();
        for (int k = 0; k < 8; k++) push_word(8'($urandom_range(255)), 1'b0);
        wait_drained();

        // let any stray result show up
        repeat (20) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS http_response_header_parser");
        end else begin
            $display("FAIL http_response_header_parser");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/hrp_pkg.sv
hdl/hrp_if.sv
hdl/hrp_front.sv
hdl/hrp_fifo.sv
hdl/hrp_back.sv
hdl/http_response_header_parser.sv
sim/http_response_header_parser_tb.sv
